// ===== rtl/u8bmp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package u8bmp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // One byte of the incoming string
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_word_t;

  // One decoded result
  typedef struct packed {
    logic [15:0] code_unit;
    logic [1:0]  kind;
    logic        last;
  } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/utf8_to_bmp_code_unit_decoder.sv =====
// UTF-8 to 16-bit code unit decoder.
// src channel: one string byte per word (data_byte, end_of_string), valid/stall.
// res channel: one result word (code_unit, kind, last), valid/stall.
// Each accepted byte updates a small decode state in the same cycle; a byte
// that completes a sequence, hits a bad lead or ends the string yields one
// result word, registered on res, or parked in the skid register while the
// receiver stalls. Other bytes yield nothing. The block takes one byte per
// cycle while src_stall is low. A one-word skid register sits behind the
// result register, so the block still takes a byte while a result waits on
// a stalled receiver; src_stall rises only when both the result and skid
// registers are full and falls as soon as the receiver takes a word.
// Reset (rst, synchronous) clears the decode state and empties both output
// registers. After a bad lead the rest of the string is dropped, and its
// final byte gives an end marker result with last set.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_bmp_code_unit_decoder (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   src_valid,
  output logic                  src_stall,
  input  wire u8bmp_pkg::in_word_t  src_word,
  output logic                  res_valid,
  input  wire                   res_stall,
  output u8bmp_pkg::out_word_t  res_word
);
  import u8bmp_pkg::*;

  // Decode state
  logic [1:0] bytes_pending, bytes_pending_next;
  logic [9:0] partial_bits, partial_bits_next;
  logic       discarding, discarding_next;

  // Output and skid registers
  out_word_t skid_word;
  logic      skid_valid;

  logic      src_fire;
  logic      res_fire;
  logic      has_res;
  out_word_t res_calc;
  logic [7:0]  b;
  logic        eos;
  logic [15:0] acc;

  assign src_stall = skid_valid;
  assign src_fire  = src_valid && !src_stall;
  assign res_fire  = res_valid && !res_stall;

  assign b   = src_word.data_byte;
  assign eos = src_word.end_of_string;
  assign acc = {partial_bits, b[5:0]};

  // Decode one byte against the current state
  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_bits_next  = partial_bits;
    discarding_next    = discarding;
    has_res            = 1'b0;
    res_calc           = '{code_unit: 16'd0, kind: KIND_CHAR, last: eos};
    if (discarding) begin
      if (eos) begin
        discarding_next = 1'b0;
        has_res         = 1'b1;
        res_calc.kind   = KIND_END;
      end
    end else if (bytes_pending != 2'd0) begin
      bytes_pending_next = bytes_pending - 2'd1;
      if (bytes_pending == 2'd1) begin
        partial_bits_next  = 10'd0;
        has_res            = 1'b1;
        res_calc.code_unit = acc;
      end else if (eos) begin
        bytes_pending_next = 2'd0;
        partial_bits_next  = 10'd0;
        has_res            = 1'b1;
        res_calc.kind      = KIND_ERROR;
      end else begin
        partial_bits_next = acc[9:0];
      end
    end else if (!b[7]) begin
      has_res            = 1'b1;
      res_calc.code_unit = {8'd0, b};
    end else if ((b > 8'hc0) && (b < 8'hf0)) begin
      if (eos) begin
        has_res       = 1'b1;
        res_calc.kind = KIND_ERROR;
      end else if (b < 8'he0) begin
        partial_bits_next  = {5'd0, b[4:0]};
        bytes_pending_next = 2'd1;
      end else begin
        partial_bits_next  = {6'd0, b[3:0]};
        bytes_pending_next = 2'd2;
      end
    end else begin
      has_res         = 1'b1;
      res_calc.kind   = KIND_ERROR;
      discarding_next = !eos;
    end
  end

  // Advance decode state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      partial_bits  <= 10'd0;
      discarding    <= 1'b0;
    end else if (src_fire) begin
      bytes_pending <= bytes_pending_next;
      partial_bits  <= partial_bits_next;
      discarding    <= discarding_next;
    end
  end

  // Load result register, park a result in the skid register when held
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || res_fire) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= src_fire && has_res;
      end
    end else if (src_fire && has_res) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!res_valid || res_fire) begin
      if (skid_valid) begin
        res_word <= skid_word;
      end else if (src_fire && has_res) begin
        res_word <= res_calc;
      end
    end else if (src_fire && has_res) begin
      skid_word <= res_calc;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u8bmp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u8bmp_checker (
  input wire                       clk,
  input wire                       rst,
  input wire                       src_valid,
  input wire                       src_stall,
  input wire u8bmp_pkg::in_word_t  src_word,
  input wire                       res_valid,
  input wire                       res_stall,
  input wire u8bmp_pkg::out_word_t res_word
);
  import u8bmp_pkg::*;

  // Hold a stalled source word
  a_src_hold: assert property (@(posedge clk) disable iff (rst)
    src_valid && src_stall |=> src_valid && $stable(src_word))
    else $error("source word changed while stalled");

  // Hold a stalled result word
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_word))
    else $error("result word changed while stalled");

  // Stall the source only after the receiver held a word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(src_stall) |-> $past(res_valid && res_stall))
    else $error("source stalled without a held result");

  // Non-character results carry a zero code unit
  a_zero_code: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_word.kind != KIND_CHAR) |-> res_word.code_unit == 16'd0)
    else $error("error or end word with nonzero code unit");

  // An end marker always closes a string
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_word.kind == KIND_END) |-> res_word.last)
    else $error("end marker without last");

endmodule

bind utf8_to_bmp_code_unit_decoder u8bmp_checker u_u8bmp_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_stall (src_stall),
  .src_word  (src_word),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_word  (res_word)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import u8bmp_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int TARGET_BYTES = 1100;
  localparam int PHASE_BYTES  = 220;

  // Tracks the decode state and holds the code unit words still owed by the block
  class decode_tracker;
    logic [1:0]  cont_left;
    logic [9:0]  bits_so_far;
    logic        skipping;
    out_word_t   expected_units[$];
    int          errors;

    function new();
      cont_left   = '0;
      bits_so_far = '0;
      skipping    = 1'b0;
      errors      = 0;
    endfunction

    function int waiting();
      return expected_units.size();
    endfunction

    // Advance the decode state by one accepted byte word; queue any result it gives
    function void take_byte(in_word_t w);
      out_word_t   r;
      logic        hit;
      logic [15:0] acc;
      logic [7:0]  b;
      logic        eos;
      b   = w.data_byte;
      eos = w.end_of_string;
      r   = '0;
      hit = 1'b0;
      if (skipping) begin
        // drop bytes until the string ends, then give the end marker
        if (eos) begin
          skipping = 1'b0;
          r.kind   = KIND_END;
          r.last   = 1'b1;
          hit      = 1'b1;
        end
      end else if (cont_left != 2'd0) begin
        acc = {bits_so_far, b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          bits_so_far = '0;
          r.code_unit = acc;
          r.kind      = KIND_CHAR;
          r.last      = eos;
          hit         = 1'b1;
        end else if (eos) begin
          // string ends inside a three-byte sequence
          cont_left   = '0;
          bits_so_far = '0;
          r.kind      = KIND_ERROR;
          r.last      = 1'b1;
          hit         = 1'b1;
        end else begin
          bits_so_far = acc[9:0];
        end
      end else if (b < 8'h80) begin
        r.code_unit = {8'h00, b};
        r.kind      = KIND_CHAR;
        r.last      = eos;
        hit         = 1'b1;
      end else if (b > 8'hC0 && b < 8'hF0) begin
        // multi-byte lead: a final lead byte is a truncated sequence
        if (eos) begin
          r.kind = KIND_ERROR;
          r.last = 1'b1;
          hit    = 1'b1;
        end else if (b < 8'hE0) begin
          bits_so_far = {5'd0, b[4:0]};
          cont_left   = 2'd1;
        end else begin
          bits_so_far = {6'd0, b[3:0]};
          cont_left   = 2'd2;
        end
      end else begin
        // bad lead: flag it and skip the rest of the string
        r.kind   = KIND_ERROR;
        r.last   = eos;
        hit      = 1'b1;
        skipping = !eos;
      end
      if (hit) expected_units.push_back(r);
    endfunction

    // Compare one accepted result word with the oldest expectation
    function void match_result(out_word_t got);
      out_word_t want;
      if (expected_units.size() == 0) begin
        $error("result word with nothing expected: code_unit %h kind %0d last %0d",
               got.code_unit, got.kind, got.last);
        errors++;
        return;
      end
      want = expected_units.pop_front();
      if (got.code_unit !== want.code_unit) begin
        $error("code_unit: expected %h, got %h", want.code_unit, got.code_unit);
        errors++;
      end
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_stall;
  in_word_t  src_word = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_word_t res_word;

  decode_tracker tracker;
  int gap_pct   = 0;
  int stall_pct = 0;
  int stall_run = 0;
  int bytes_sent = 0;
  int cycles = 0;

  utf8_to_bmp_code_unit_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stall the result side in runs: mostly short, now and then long
  always @(negedge clk) begin
    if (stall_run > 0) begin
      res_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      res_stall <= 1'b1;
      stall_run <= ($urandom_range(14) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 1);
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Check every result word taken by the receiver
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) tracker.match_result(res_word);
  end

  function automatic int pick_gap();
    if ($urandom_range(99) >= gap_pct) return 0;
    return ($urandom_range(14) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 2);
  endfunction

  function automatic logic [7:0] cont_byte();
    // mostly proper continuation bytes, sometimes anything at all
    if ($urandom_range(4) == 0) return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  // Present one byte word, hold it until taken, then log it
  task automatic send_byte(input in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      src_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    src_valid <= 1'b1;
    src_word  <= w;
    do @(posedge clk); while (src_stall);
    tracker.take_byte(w);
    bytes_sent++;
  endtask

  // Build one string: mostly well-formed text, some cut short, corrupted or pure noise
  task automatic send_string();
    logic [7:0] text[$];
    int shape;
    int n;
    int cut;
    shape = $urandom_range(99);
    if (shape < 12) begin
      n = $urandom_range(1, 8);
      repeat (n) text.push_back(8'($urandom));
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        case ($urandom_range(2))
          0: text.push_back(8'($urandom_range(0, 127)));
          1: begin
            text.push_back(8'($urandom_range(8'hC1, 8'hDF)));
            text.push_back(cont_byte());
          end
          default: begin
            text.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            text.push_back(cont_byte());
            text.push_back(cont_byte());
          end
        endcase
      end
      if (shape < 24) begin
        cut = $urandom_range(1, text.size());
        while (text.size() > cut) void'(text.pop_back());
      end else if (shape < 34) begin
        text[$urandom_range(0, text.size() - 1)] = 8'($urandom);
      end
    end
    for (int i = 0; i < text.size(); i++) send_byte({text[i], i == text.size() - 1});
  endtask

  // Hold the sender until the block has delivered everything owed
  task automatic drain();
    @(negedge clk);
    src_valid <= 1'b0;
    while (tracker.waiting() != 0) @(posedge clk);
  endtask

  in_word_t opening [0:24] = '{
    {8'h00, 1'b0}, {8'h7F, 1'b0},
    {8'hC1, 1'b0}, {8'h80, 1'b0}, {8'hDF, 1'b0}, {8'hFF, 1'b0},
    {8'hE0, 1'b0}, {8'h80, 1'b0}, {8'h80, 1'b0},
    {8'hEF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b1},
    {8'hC0, 1'b0}, {8'h41, 1'b0}, {8'hE2, 1'b1},
    {8'hF0, 1'b1},
    {8'h80, 1'b0}, {8'hFF, 1'b1},
    {8'hC5, 1'b1},
    {8'hE2, 1'b0}, {8'h82, 1'b1},
    {8'hFF, 1'b0}, {8'h00, 1'b1},
    {8'h41, 1'b1}, {8'h00, 1'b1}
  };

  int gap_mix   [0:4] = '{0, 30, 10, 60, 50};
  int stall_mix [0:4] = '{0, 30, 60, 10, 50};

  initial begin
    int phase;
    int phase_start;
    tracker = new();
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed strings: range ends, every sequence length, error paths
    for (int i = 0; i <= 24; i++) send_byte(opening[i]);
    drain();

    // Random strings under shifting idle and stall mixes
    phase = 0;
    while (bytes_sent < TARGET_BYTES) begin
      gap_pct   = gap_mix[phase % 5];
      stall_pct = stall_mix[phase % 5];
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES && bytes_sent < TARGET_BYTES)
        send_string();
      drain();
      phase++;
    end

    // Release the receiver and let any stray word show up
    stall_pct = 0;
    drain();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.waiting() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/u8bmp_pkg.sv
rtl/utf8_to_bmp_code_unit_decoder.sv
rtl/u8bmp_checker.sv
tb/testbench.sv
